>>> sv/htac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htac_pkg
// Shared widths, register indexes and pipeline types for the heat color ramp.
// ----------------------------------------------------------------------------
package htac_pkg;

   localparam int HEAT_WIDTH  = 24;
   localparam int CSR_W       = (HEAT_WIDTH > 16) ? HEAT_WIDTH : 16;
   localparam int REQ_TDATA_W = ((HEAT_WIDTH + 7) / 8) * 8;
   localparam int EPS_W       = 16;
   localparam int Q_W         = 16;          // quotient bits of the intensity
   localparam int T_W         = Q_W + 1;     // intensity incl. the 1.0 code
   localparam int A3_W        = T_W + 1;
   localparam int CH_W        = 8;
   localparam int RSP_TDATA_W = 4 * CH_W;

   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_HEAT_CEILING = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_EPSILON      = 1'd1;

   localparam logic [T_W-1:0]  ONE_Q16   = T_W'(65536);
   localparam logic [A3_W-1:0] A3_LIMIT  = A3_W'(131072);
   localparam logic [7:0]      ALPHA_MAX = 8'd220;
   localparam logic [CH_W-1:0] CH_FULL   = 8'd255;

   localparam logic [1:0] SEG_BLUE   = 2'd0;
   localparam logic [1:0] SEG_CYAN   = 2'd1;
   localparam logic [1:0] SEG_YELLOW = 2'd2;
   localparam logic [1:0] SEG_RED    = 2'd3;

   // One item moving through the divider stages
   typedef struct packed {
      logic                  valid;
      logic                  zero;   // ceiling at or below epsilon
      logic                  sat;    // heat at or above ceiling
      logic [HEAT_WIDTH-1:0] rem;
      logic [Q_W-1:0]        quot;
   } div_type;

   typedef struct packed {
      logic [CH_W-1:0] alpha;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } argb_type;

endpackage

>>> sv/htac_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htac_skid
// Input skid register: keeps req_tready a flop output while the pipe stalls.
// ----------------------------------------------------------------------------
module htac_skid
   import htac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [HEAT_WIDTH-1:0] in_heat,
   input  logic                  pipe_en,
   output logic                  out_valid,
   output logic [HEAT_WIDTH-1:0] out_heat
);

   logic                  full_ff, full_in;
   logic [HEAT_WIDTH-1:0] heat_ff;

   assign in_ready  = !full_ff;
   assign out_valid = full_ff || in_valid;
   assign out_heat  = full_ff ? heat_ff : in_heat;

   always_comb begin
      full_in = full_ff;
      if (full_ff && pipe_en) begin
         full_in = 1'b0;
      end else if (!full_ff && in_valid && !pipe_en) begin
         full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   // capture a transaction the stalled pipe could not take
   always_ff @(posedge clock) begin
      if (!full_ff && in_valid && !pipe_en) begin
         heat_ff <= in_heat;
      end
   end

`ifndef ASSERT_OFF
   a_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(full_ff) |-> $past(!pipe_en && in_valid))
      else $error("skid filled without a stalled transaction");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      full_ff && !pipe_en |=> full_ff)
      else $error("skid dropped a transaction during a stall");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      full_ff && pipe_en |=> !full_ff)
      else $error("skid did not drain");
`endif

endmodule

>>> sv/htac_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htac_div_stage
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module htac_div_stage
   import htac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [HEAT_WIDTH-1:0] ceiling,
   input  div_type               in_st,
   output div_type               out_st
);

   logic [HEAT_WIDTH:0] rem2;
   logic [HEAT_WIDTH:0] div_ext;
   logic                ge;
   logic [HEAT_WIDTH:0] rem_next;
   div_type             st_ff, st_in;

   always_comb begin
      rem2     = {in_st.rem, 1'b0};
      div_ext  = {1'b0, ceiling};
      ge       = (rem2 >= div_ext);
      rem_next = ge ? (rem2 - div_ext) : rem2;
      st_in      = in_st;
      st_in.rem  = rem_next[HEAT_WIDTH-1:0];
      st_in.quot = {in_st.quot[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_st = st_ff;

endmodule

>>> sv/htac_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htac_color
// Two stages: intensity, segment and ramp amount, then alpha and channel mix.
// ----------------------------------------------------------------------------
module htac_color
   import htac_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [EPS_W-1:0] epsilon,
   input  div_type          in_st,
   output logic             out_valid,
   output argb_type         out_px
);

   // stage A
   logic [T_W-1:0]  t;
   logic [A3_W-1:0] a3_raw;
   logic            a_valid_ff;
   logic            blank_ff, blank_in;
   logic [1:0]      seg_ff, seg_in;
   logic [T_W-1:0]  amount_ff, amount_in;
   logic [A3_W-1:0] a3_ff, a3_in;

   always_comb begin
      t         = in_st.sat ? ONE_Q16 : {1'b0, in_st.quot};
      blank_in  = in_st.zero || (t <= T_W'(epsilon));
      a3_raw    = {t, 1'b0} + {1'b0, t};
      a3_in     = (a3_raw > A3_LIMIT) ? A3_LIMIT : a3_raw;
      seg_in    = t[T_W-1] ? SEG_RED : t[Q_W-1:Q_W-2];
      amount_in = t[T_W-1] ? ONE_Q16 : {1'b0, t[Q_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_st.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         blank_ff  <= blank_in;
         seg_ff    <= seg_in;
         amount_ff <= amount_in;
         a3_ff     <= a3_in;
      end
   end

   // stage B
   logic [25:0] alpha_sum;
   logic [24:0] ramp_x;
   logic [24:0] up_sum;
   logic [24:0] down_sum;
   logic [7:0]  up_ch, down_ch;
   logic        b_valid_ff;
   argb_type    px_ff, px_in;

   always_comb begin
      alpha_sum = 26'(a3_ff) * 26'(ALPHA_MAX) + 26'd65536;
      ramp_x    = {amount_ff, 8'b0} - 25'(amount_ff);       // 255 * amount
      up_sum    = ramp_x + 25'd32768;
      down_sum  = 25'd16744448 - ramp_x;                      // 255.5 - 255 * amount
      up_ch     = up_sum[23:16];
      down_ch   = down_sum[23:16];
      px_in.alpha = alpha_sum[24:17];
      case (seg_ff)
         SEG_BLUE: begin
            px_in.red = '0;      px_in.green = '0;      px_in.blue = CH_FULL;
         end
         SEG_CYAN: begin
            px_in.red = '0;      px_in.green = up_ch;   px_in.blue = CH_FULL;
         end
         SEG_YELLOW: begin
            px_in.red = up_ch;   px_in.green = CH_FULL; px_in.blue = down_ch;
         end
         default: begin
            px_in.red = CH_FULL; px_in.green = down_ch; px_in.blue = '0;
         end
      endcase
      if (blank_ff) begin
         px_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_px    = px_ff;

`ifndef ASSERT_OFF
   a_red_mid_green_full: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && px_ff.red != '0 && px_ff.red != CH_FULL |-> px_ff.green == CH_FULL)
      else $error("red ramps outside the yellow segment");
   a_blank_black: assert property (@(posedge clock) disable iff (reset)
      en && a_valid_ff && blank_ff |=> px_ff == '0)
      else $error("blanked pixel is not transparent black");
   a_blue_ramp: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && px_ff.blue != '0 && px_ff.blue != CH_FULL |-> px_ff.green == CH_FULL)
      else $error("blue ramps outside the yellow segment");
`endif

endmodule

>>> sv/heat_to_argb_color_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_to_argb_color_ramp
// Maps a pixel's unsigned heat value to an ARGB color through a blue, cyan,
// yellow, red ramp normalized against a programmable heat ceiling.
//
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------
//  req_*    | in        | tdata: heat_value
//  rsp_*    | out       | tdata: blue_out, green_out, red_out, alpha_out
//  csr_*    | in        | write enable, register index, write data
//
// One pixel per clock sustained while the output is taken; one entry stage,
// sixteen restoring-division stages (one quotient bit each) and two color stages.
// Synchronous reset clears all valid bits and loads ceiling 1.0, epsilon 1.
// The whole pipe advances when the output is empty or taken; a transaction
// arriving during a stall waits in the input skid register.
// ----------------------------------------------------------------------------
module heat_to_argb_color_ramp
   import htac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [HEAT_WIDTH-1:0] heat_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // blue_out, green_out, red_out, alpha_out
   input  logic                   csr_we,
   input  logic [REG_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   logic [HEAT_WIDTH-1:0] ceiling_ff;
   logic [EPS_W-1:0]      epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= HEAT_WIDTH'(256);
         epsilon_ff <= EPS_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_HEAT_CEILING: ceiling_ff <= csr_wdata[HEAT_WIDTH-1:0];
            REG_EPSILON:      epsilon_ff <= csr_wdata[EPS_W-1:0];
            default:          ;
         endcase
      end
   end

   logic                  pipe_en;
   logic                  src_valid;
   logic [HEAT_WIDTH-1:0] src_heat;
   argb_type              px;

   assign pipe_en = rsp_tready || !rsp_tvalid;

   htac_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_heat   (req_tdata[HEAT_WIDTH-1:0]),
      .pipe_en   (pipe_en),
      .out_valid (src_valid),
      .out_heat  (src_heat)
   );

   // entry stage: flags and initial remainder
   div_type entry_ff, entry_in;

   always_comb begin
      entry_in.valid = src_valid;
      entry_in.zero  = ({ceiling_ff, 8'b0} <= (HEAT_WIDTH + 8)'(epsilon_ff));
      entry_in.sat   = (src_heat >= ceiling_ff);
      entry_in.rem   = src_heat;
      entry_in.quot  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         entry_ff <= entry_in;
      end
   end

   div_type div_st [Q_W+1];

   assign div_st[0] = entry_ff;

   for (genvar i = 0; i < Q_W; i++) begin : g_div
      htac_div_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .ceiling (ceiling_ff),
         .in_st   (div_st[i]),
         .out_st  (div_st[i+1])
      );
   end

   htac_color u_color (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .epsilon   (epsilon_ff),
      .in_st     (div_st[Q_W]),
      .out_valid (rsp_tvalid),
      .out_px    (px)
   );

   assign rsp_tdata = {px.blue, px.green, px.red, px.alpha};

`ifndef ASSERT_OFF
   a_ready_on_skid: assert property (@(posedge clock) disable iff (reset)
      !req_tready && pipe_en |=> req_tready)
      else $error("input stayed blocked after the pipe advanced");
   a_entry_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(entry_ff))
      else $error("entry stage changed during a stall");
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      entry_ff.valid && entry_ff.sat && pipe_en |=> div_st[1].sat)
      else $error("saturation flag lost in the divider");
`endif

endmodule
